>>> rtl/knn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package knn_pkg;

  // Default sizes of the store.
  localparam int CAPACITY_DEF = 1024;
  localparam int DIM_MAX_DEF  = 64;
  localparam int K_MAX_DEF    = 16;

  // Fixed field widths of the ports.
  localparam int VALUE_BITS = 16;
  localparam int ID_BITS    = 10;
  localparam int CNT_BITS   = 11;
  localparam int DIST_BITS  = 38;
  localparam int K_BITS     = 5;
  localparam int IDX_BITS   = 6;
  localparam int DIM_BITS   = 7;
  localparam int LEN_BITS   = 11;
  localparam int SQ_BITS    = 33;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_INSERT    = 2'd0,
    KIND_NEIGHBOUR = 2'd1,
    KIND_READ      = 2'd2,
    KIND_CLEAR     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_FULL     = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_RESULT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_SCAN   = 2'd2
  } cmd_type_t;

  // Work handed from the front to the back.
  typedef struct packed {
    cmd_type_t             ctype;
    kind_t                 kind;
    status_t               status;
    logic [ID_BITS-1:0]    vec_id;
    logic [CNT_BITS-1:0]   count;
    logic [LEN_BITS-1:0]   len;
    logic [K_BITS-1:0]     k;
    logic [ID_BITS-1:0]    read_id;
    logic [IDX_BITS-1:0]   read_index;
  } cmd_t;

endpackage
`default_nettype wire

>>> rtl/knn_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module knn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/knn_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module knn_queue
  import knn_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty,
  output logic      full
);

  localparam int QA_W = $clog2(QUEUE_DEPTH);

  cmd_t            mem [QUEUE_DEPTH];
  logic [QA_W-1:0] wp;
  logic [QA_W-1:0] rp;
  logic [QA_W:0]   fill;

  assign head  = mem[rp];
  assign empty = (fill == '0);
  assign full  = (fill == (QA_W + 1)'(QUEUE_DEPTH));

  // Storage of queued commands.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_cmd;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command popped from an empty queue");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> fill == $past(fill) + 1'b1)
    else $error("queue occupancy did not follow a push");

endmodule
`default_nettype wire

>>> rtl/knn_front.sv
`timescale 1ns / 1ps
`default_nettype none
module knn_front
  import knn_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int DIM_MAX  = DIM_MAX_DEF,
  parameter int K_MAX    = K_MAX_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            op,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic                  last,
  input  wire logic [K_BITS-1:0]     k,
  input  wire logic [ID_BITS-1:0]    read_id,
  input  wire logic [IDX_BITS-1:0]   read_index,
  input  wire logic                  dimension_we,
  input  wire logic [DIM_BITS-1:0]   dimension,
  input  wire logic                  queue_full,
  input  wire logic                  queue_empty,
  input  wire logic                  back_idle,
  output logic                       push,
  output cmd_t                       cmd,
  output logic                       st_we,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1) + (DIM_MAX > 1 ? $clog2(DIM_MAX) : 1)-1:0]
                                     st_waddr,
  output logic [VALUE_BITS-1:0]      st_wdata,
  output logic                       qb_we,
  output logic [(DIM_MAX > 1 ? $clog2(DIM_MAX) : 1)-1:0] qb_waddr,
  output logic [VALUE_BITS-1:0]      qb_wdata
);

  localparam int ID_W  = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
  localparam int DIM_W = DIM_MAX > 1 ? $clog2(DIM_MAX) : 1;
  localparam int POS_W = $clog2(DIM_MAX + 2);

  logic [DIM_BITS-1:0] dim_reg;
  logic [DIM_BITS-1:0] learned_dim;
  logic [DIM_BITS-1:0] learned_dim_next;
  logic [POS_W-1:0]    pos;
  logic [POS_W-1:0]    pos_next;
  logic                loading_query;
  logic                loading_query_next;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;

  logic                accept;
  logic                is_vec;
  logic [DIM_BITS-1:0] edim;
  logic [POS_W-1:0]    pos_eff;
  logic [POS_W-1:0]    pos_inc;
  logic                in_range;
  logic                mismatch;
  logic                full;
  logic [K_BITS-1:0]   k_sat;

  // Vector components touch the memories, so they wait until the back is quiet.
  assign is_vec   = (op == OP_INSERT) || (op == OP_QUERY);
  assign in_stall = queue_full || (is_vec && !(queue_empty && back_idle));
  assign accept   = in_valid && !in_stall;

  // Classification of the incoming transaction.
  assign edim     = (learned_dim != '0) ? learned_dim : dim_reg;
  assign pos_eff  = (pos != '0 && loading_query != op[0]) ? '0 : pos;
  assign pos_inc  = (32'(pos_eff) <= DIM_MAX) ? pos_eff + 1'b1 : pos_eff;
  assign in_range = 32'(pos_eff) < DIM_MAX;
  assign mismatch = (32'(pos_inc) > DIM_MAX)
                 || (edim != '0 && LEN_BITS'(pos_inc) != LEN_BITS'(edim));
  assign full     = 32'(count) >= CAPACITY;
  assign k_sat    = (32'(k) > K_MAX) ? K_BITS'(K_MAX) : k;

  // Memory writes of components.
  assign st_we    = accept && (op == OP_INSERT) && in_range && !full;
  assign st_waddr = {ID_W'(count), DIM_W'(pos_eff)};
  assign st_wdata = value;
  assign qb_we    = accept && (op == OP_QUERY) && in_range;
  assign qb_waddr = DIM_W'(pos_eff);
  assign qb_wdata = value;

  // Next state and the command for the back.
  always_comb begin
    push               = 1'b0;
    count_next         = count;
    learned_dim_next   = learned_dim;
    pos_next           = pos;
    loading_query_next = loading_query;
    cmd                = '0;
    cmd.ctype          = CMD_RESULT;
    cmd.kind           = KIND_INSERT;
    cmd.status         = ST_OK;
    cmd.read_id        = read_id;
    cmd.read_index     = read_index;
    cmd.len            = LEN_BITS'(pos_inc);
    cmd.k              = k_sat;
    unique case (op_t'(op))
      OP_INSERT: begin
        loading_query_next = 1'b0;
        pos_next           = last ? '0 : pos_inc;
        if (last) begin
          push = 1'b1;
          if (mismatch) begin
            cmd.status = ST_MISMATCH;
          end else if (full) begin
            cmd.status = ST_FULL;
          end else begin
            cmd.vec_id       = ID_BITS'(count);
            count_next       = count + 1'b1;
            learned_dim_next = DIM_BITS'(pos_inc);
          end
        end
      end
      OP_QUERY: begin
        loading_query_next = 1'b1;
        pos_next           = last ? '0 : pos_inc;
        cmd.kind           = KIND_NEIGHBOUR;
        if (last) begin
          if (mismatch) begin
            push       = 1'b1;
            cmd.status = ST_MISMATCH;
          end else if (k_sat != '0 && count != '0) begin
            push      = 1'b1;
            cmd.ctype = CMD_SCAN;
          end
        end
      end
      OP_CLEAR: begin
        push       = 1'b1;
        count_next = '0;
        pos_next   = '0;
        cmd.kind   = KIND_CLEAR;
      end
      OP_READ: begin
        push     = 1'b1;
        cmd.kind = KIND_READ;
        if (32'(read_id) >= 32'(count) || DIM_BITS'(read_index) >= edim
            || 32'(read_index) >= DIM_MAX) begin
          cmd.status = ST_RANGE;
        end else begin
          cmd.ctype = CMD_READ;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
    cmd.count = count_next;
    if (!accept) begin
      push = 1'b0;
    end
  end

  // Architectural state of the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_reg       <= '0;
      learned_dim   <= '0;
      pos           <= '0;
      loading_query <= 1'b0;
      count         <= '0;
    end else begin
      if (dimension_we) begin
        dim_reg <= dimension;
      end
      if (accept) begin
        learned_dim   <= learned_dim_next;
        pos           <= pos_next;
        loading_query <= loading_query_next;
        count         <= count_next;
      end
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst) 32'(pos) <= DIM_MAX + 1)
    else $error("component position ran past the overlong mark");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) 32'(count) <= CAPACITY)
    else $error("vector count exceeds capacity");
  a_vec_quiet: assert property (@(posedge clk) disable iff (rst)
      (st_we || qb_we) |-> (queue_empty && back_idle))
    else $error("component written while the back may read memory");

endmodule
`default_nettype wire

>>> rtl/knn_back.sv
`timescale 1ns / 1ps
`default_nettype none
module knn_back
  import knn_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int DIM_MAX  = DIM_MAX_DEF,
  parameter int K_MAX    = K_MAX_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cmd_valid,
  input  cmd_t                        cmd,
  output logic                        pop,
  output logic                        idle,
  output logic                        st_re,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1) + (DIM_MAX > 1 ? $clog2(DIM_MAX) : 1)-1:0]
                                      st_raddr,
  input  wire logic [VALUE_BITS-1:0]  st_rdata,
  output logic                        qb_re,
  output logic [(DIM_MAX > 1 ? $clog2(DIM_MAX) : 1)-1:0] qb_raddr,
  input  wire logic [VALUE_BITS-1:0]  qb_rdata,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  kind,
  output logic [1:0]                  status,
  output logic [ID_BITS-1:0]          vec_id,
  output logic [DIST_BITS-1:0]        distance,
  output logic [VALUE_BITS-1:0]       data,
  output logic [CNT_BITS-1:0]         stored_count,
  output logic                        final_res
);

  localparam int ID_W  = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
  localparam int DIM_W = DIM_MAX > 1 ? $clog2(DIM_MAX) : 1;
  localparam int KI_W  = K_MAX > 1 ? $clog2(K_MAX) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ISSUE,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t              state;
  cmd_t                cur;
  logic [ID_W-1:0]     vi;
  logic [DIM_W-1:0]    ci;
  logic [KI_W-1:0]     e;
  logic                slot_free;
  logic                load_out;
  logic                last_c;
  logic                last_v;
  logic [K_BITS-1:0]   nemit;
  logic                emit_last;

  // Distance pipeline.
  logic                  p1;
  logic                  p1_last;
  logic [ID_W-1:0]       p1_id;
  logic                  p2;
  logic                  p2_last;
  logic [ID_W-1:0]       p2_id;
  logic [SQ_BITS-1:0]    sq;
  logic [DIST_BITS-1:0]  acc;
  logic                  dv;
  logic [DIST_BITS-1:0]  dd;
  logic [ID_W-1:0]       did;
  logic signed [VALUE_BITS:0]       diff;
  logic signed [2*VALUE_BITS+1:0]   prod;

  // Sorted best list.
  logic [DIST_BITS-1:0] dist_l [K_MAX];
  logic [ID_BITS-1:0]   id_l   [K_MAX];
  logic [K_MAX-1:0]     ins;

  assign slot_free = !out_valid || !out_stall;
  assign idle      = (state == S_IDLE);
  assign pop       = (state == S_IDLE) && cmd_valid
                  && (cmd.ctype != CMD_RESULT || slot_free);
  assign last_c    = LEN_BITS'(ci) == cur.len - 1'b1;
  assign last_v    = CNT_BITS'(vi) == cur.count - 1'b1;
  assign nemit     = ({6'b0, cur.k} < cur.count) ? cur.k : K_BITS'(cur.count);
  assign emit_last = K_BITS'(e) == nemit - 1'b1;

  // A new result enters the output register in this cycle.
  assign load_out  = ((state == S_IDLE) && pop && cmd.ctype == CMD_RESULT)
                  || ((state == S_READ || state == S_EMIT) && slot_free);

  // Memory reads: one component pair per cycle while scanning.
  always_comb begin
    st_re    = (pop && cmd.ctype == CMD_READ) || (state == S_ISSUE);
    qb_re    = (state == S_ISSUE);
    qb_raddr = ci;
    if (state == S_ISSUE) begin
      st_raddr = {vi, ci};
    end else begin
      st_raddr = {ID_W'(cmd.read_id), DIM_W'(cmd.read_index)};
    end
  end

  // Difference and square of one component pair.
  assign diff = $signed({qb_rdata[VALUE_BITS-1], qb_rdata})
              - $signed({st_rdata[VALUE_BITS-1], st_rdata});
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
      dv <= 1'b0;
    end else begin
      p1 <= (state == S_ISSUE);
      p2 <= p1;
      dv <= p2 && p2_last;
    end
  end

  always_ff @(posedge clk) begin
    p1_last <= last_c;
    p1_id   <= vi;
    p2_last <= p1_last;
    p2_id   <= p1_id;
    sq      <= SQ_BITS'(prod);
    if (state == S_IDLE) begin
      acc <= '0;
    end else if (p2) begin
      if (p2_last) begin
        acc <= '0;
        dd  <= acc + DIST_BITS'(sq);
        did <= p2_id;
      end else begin
        acc <= acc + DIST_BITS'(sq);
      end
    end
  end

  // Insertion: entries at or beyond the current id are still empty.
  always_comb begin
    for (int j = 0; j < K_MAX; j++) begin
      ins[j] = (32'(j) >= 32'(did)) || (dd < dist_l[j]);
    end
  end

  for (genvar g = 0; g < K_MAX; g++) begin : g_slot
    always_ff @(posedge clk) begin
      if (dv && ins[g]) begin
        if (g == 0) begin
          dist_l[g] <= dd;
          id_l[g]   <= ID_BITS'(did);
        end else if (!ins[(g == 0) ? 0 : g-1]) begin
          dist_l[g] <= dd;
          id_l[g]   <= ID_BITS'(did);
        end else begin
          dist_l[g] <= dist_l[(g == 0) ? 0 : g-1];
          id_l[g]   <= id_l[(g == 0) ? 0 : g-1];
        end
      end
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      vi        <= '0;
      ci        <= '0;
      e         <= '0;
    end else begin
      // The result register fills on a load and empties when its transaction is taken.
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cur <= cmd;
            vi  <= '0;
            ci  <= '0;
            unique case (cmd.ctype)
              CMD_READ: state <= S_READ;
              CMD_SCAN: state <= S_ISSUE;
              default: begin
                kind         <= cmd.kind;
                status       <= cmd.status;
                vec_id       <= cmd.vec_id;
                distance     <= '0;
                data         <= '0;
                stored_count <= cmd.count;
                final_res    <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          if (slot_free) begin
            kind         <= KIND_READ;
            status       <= ST_OK;
            vec_id       <= '0;
            distance     <= '0;
            data         <= st_rdata;
            stored_count <= cur.count;
            final_res    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_ISSUE: begin
          if (last_c) begin
            ci <= '0;
            vi <= vi + 1'b1;
            if (last_v) begin
              state <= S_DRAIN;
            end
          end else begin
            ci <= ci + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!p1 && !p2 && !dv) begin
            e     <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            kind         <= KIND_NEIGHBOUR;
            status       <= ST_OK;
            vec_id       <= id_l[e];
            distance     <= dist_l[e];
            data         <= '0;
            stored_count <= cur.count;
            final_res    <= emit_last;
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              e <= e + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_emit_drained: assert property (@(posedge clk) disable iff (rst)
      state == S_EMIT |-> (!p1 && !p2 && !dv))
    else $error("neighbours emitted before the scan pipeline drained");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst) pop |-> state == S_IDLE)
    else $error("command taken while the back is busy");
  a_insert_in_scan: assert property (@(posedge clk) disable iff (rst)
      dv |-> (state == S_ISSUE || state == S_DRAIN))
    else $error("distance finished outside a scan");
  a_issue_follows: assert property (@(posedge clk) disable iff (rst)
      (state == S_ISSUE) |=> p1)
    else $error("issued read did not enter the pipeline");

endmodule
`default_nettype wire

>>> rtl/knn_vector_search.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel    Handshake                Payload
// input      in_valid / in_stall      op, value, last, k, read_id, read_index
// result     out_valid / out_stall    kind, status, vec_id, distance, data,
//                                     stored_count, final_res
// config     dimension_we             dimension
//
// Vector components are taken one per cycle while the queue is empty and the back is idle.
// Insert, clear, mismatch and bad-read results pass through the command queue into the
// registered output; a good read also waits for the registered store read.
// A query scan passes through the command queue and reads every stored component through
// the single store read port, then drains the distance pipeline and emits the neighbours.
// Reset is synchronous on rst; the store holds no valid bits and needs no clearing pass.
// A stalled result holds in the output register while the queue keeps taking commands.
module knn_vector_search
  import knn_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int DIM_MAX  = DIM_MAX_DEF,
  parameter int K_MAX    = K_MAX_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            op,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic                  last,
  input  wire logic [K_BITS-1:0]     k,
  input  wire logic [ID_BITS-1:0]    read_id,
  input  wire logic [IDX_BITS-1:0]   read_index,
  input  wire logic                  dimension_we,
  input  wire logic [DIM_BITS-1:0]   dimension,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 kind,
  output logic [1:0]                 status,
  output logic [ID_BITS-1:0]         vec_id,
  output logic [DIST_BITS-1:0]       distance,
  output logic [VALUE_BITS-1:0]      data,
  output logic [CNT_BITS-1:0]        stored_count,
  output logic                       final_res
);

  localparam int ID_W   = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
  localparam int DIM_W  = DIM_MAX > 1 ? $clog2(DIM_MAX) : 1;
  localparam int ST_DEP = CAPACITY * (2 ** DIM_W);

  logic                    push;
  cmd_t                    push_cmd;
  cmd_t                    head;
  logic                    q_empty;
  logic                    q_full;
  logic                    pop;
  logic                    back_idle;
  logic                    st_we;
  logic [ID_W+DIM_W-1:0]   st_waddr;
  logic [VALUE_BITS-1:0]   st_wdata;
  logic                    st_re;
  logic [ID_W+DIM_W-1:0]   st_raddr;
  logic [VALUE_BITS-1:0]   st_rdata;
  logic                    qb_we;
  logic [DIM_W-1:0]        qb_waddr;
  logic [VALUE_BITS-1:0]   qb_wdata;
  logic                    qb_re;
  logic [DIM_W-1:0]        qb_raddr;
  logic [VALUE_BITS-1:0]   qb_rdata;

  // Front: accepts transactions, keeps the store bookkeeping, writes components.
  knn_front #(
    .CAPACITY (CAPACITY),
    .DIM_MAX  (DIM_MAX),
    .K_MAX    (K_MAX)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .value        (value),
    .last         (last),
    .k            (k),
    .read_id      (read_id),
    .read_index   (read_index),
    .dimension_we (dimension_we),
    .dimension    (dimension),
    .queue_full   (q_full),
    .queue_empty  (q_empty),
    .back_idle    (back_idle),
    .push         (push),
    .cmd          (push_cmd),
    .st_we        (st_we),
    .st_waddr     (st_waddr),
    .st_wdata     (st_wdata),
    .qb_we        (qb_we),
    .qb_waddr     (qb_waddr),
    .qb_wdata     (qb_wdata)
  );

  // Command queue between the two halves.
  knn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Vector store and query buffer.
  knn_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ST_DEP)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  knn_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (2 ** DIM_W)
  ) u_qbuf (
    .clk   (clk),
    .we    (qb_we),
    .waddr (qb_waddr),
    .wdata (qb_wdata),
    .re    (qb_re),
    .raddr (qb_raddr),
    .rdata (qb_rdata)
  );

  // Back: runs reads and scans and drives the result register.
  knn_back #(
    .CAPACITY (CAPACITY),
    .DIM_MAX  (DIM_MAX),
    .K_MAX    (K_MAX)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (!q_empty),
    .cmd          (head),
    .pop          (pop),
    .idle         (back_idle),
    .st_re        (st_re),
    .st_raddr     (st_raddr),
    .st_rdata     (st_rdata),
    .qb_re        (qb_re),
    .qb_raddr     (qb_raddr),
    .qb_rdata     (qb_rdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .status       (status),
    .vec_id       (vec_id),
    .distance     (distance),
    .data         (data),
    .stored_count (stored_count),
    .final_res    (final_res)
  );

endmodule
`default_nettype wire
